// ===== rtl/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, constants and character-class helpers of the source lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

    localparam int LINE_WIDTH_DEF   = 24;
    localparam int COLUMN_WIDTH_DEF = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    localparam int TOKEN_LIMIT_W   = 20;
    localparam logic [TOKEN_LIMIT_W-1:0] TOKEN_LIMIT_RST = 20'd65535;

    // result field widths
    typedef logic [5:0]  kind_t;
    typedef logic [23:0] line_t;
    typedef logic [15:0] col_t;
    typedef logic [31:0] off_t;
    typedef logic [15:0] tlen_t;
    typedef logic [62:0] value_t;
    typedef logic [20:0] cnt_t;

    localparam value_t VALUE_MAX = '1;
    localparam cnt_t   CNT_SAT   = '1;

    localparam int DATA_BITS = 24 + 16 + 32 + 16 + 63 + 3 + 21;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - DATA_BITS;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam kind_t K_IDENT  = 6'd39;
    localparam kind_t K_STRING = 6'd40;
    localparam kind_t K_NUMBER = 6'd41;
    localparam kind_t K_EOF    = 6'd42;
    localparam kind_t K_FN     = 6'd27;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_NUMBER = 3'd1,
        ST_UNTERM_STR = 3'd2,
        ST_UNEXPECTED = 3'd3,
        ST_LIMIT      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        M_IDLE, M_SKIP, M_SKIP_LINE, M_SKIP_BLOCK, M_LINE, M_BLOCK,
        M_SKIP_HEX, M_SKIP_BIN, M_IDENT, M_STR, M_STR_ESC,
        M_DEC, M_HEX, M_BIN, M_HALT
    } mode_t;

    typedef struct packed {
        kind_t   kind;
        line_t   line;
        col_t    column;
        off_t    start_offset;
        tlen_t   text_length;
        value_t  number_value;
        status_t status;
        cnt_t    token_count;
        logic    last;
    } rec_t;

    typedef struct packed {
        logic v0;
        logic v1;
    } push_t;

    typedef struct packed {
        logic  hit;
        logic  two;
        kind_t kind;
    } sym_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } kw_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_bin(input logic [7:0] c);
        return c == "0" || c == "1";
    endfunction

    // digit test for the base a number mode works in
    function automatic logic in_base(input mode_t m, input logic [7:0] c);
        logic r;
        case (m)
            M_HEX, M_SKIP_HEX: r = is_hex(c);
            M_BIN, M_SKIP_BIN: r = is_bin(c);
            default:           r = is_digit(c);
        endcase
        return r;
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] r;
        if (is_digit(c))
            r = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            r = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            r = 4'(c - "A" + 8'd10);
        else
            r = 4'd0;
        return r;
    endfunction

    // acc * base + d, saturating
    function automatic value_t acc_step(input value_t acc, input mode_t m, input logic [3:0] d);
        logic [66:0] a;
        logic [66:0] p;
        a = 67'(acc);
        case (m)
            M_HEX:   p = (a << 4) + 67'(d);
            M_BIN:   p = (a << 1) + 67'(d);
            default: p = (a << 3) + (a << 1) + 67'(d);
        endcase
        return (p[66:63] != 4'd0) ? VALUE_MAX : p[62:0];
    endfunction

    function automatic sym_t symbol_kind(input logic [7:0] c, input logic [7:0] n);
        sym_t r;
        r.hit  = 1'b1;
        r.two  = 1'b0;
        r.kind = 6'd0;
        case (c)
            ";": r.kind = 6'd0;
            "(": r.kind = 6'd1;
            ")": r.kind = 6'd2;
            "{": r.kind = 6'd3;
            "}": r.kind = 6'd4;
            "@": r.kind = 6'd5;
            ",": r.kind = 6'd6;
            "*": begin r.two = (n == "="); r.kind = r.two ? 6'd8  : 6'd7;  end
            "+": begin r.two = (n == "="); r.kind = r.two ? 6'd10 : 6'd9;  end
            "/": begin r.two = (n == "="); r.kind = r.two ? 6'd12 : 6'd11; end
            "&": begin r.two = (n == "&"); r.kind = r.two ? 6'd14 : 6'd13; end
            "=": begin r.two = (n == "="); r.kind = r.two ? 6'd16 : 6'd15; end
            "!": begin r.two = (n == "="); r.kind = r.two ? 6'd18 : 6'd17; end
            "<": begin r.two = (n == "="); r.kind = r.two ? 6'd20 : 6'd19; end
            ">": begin r.two = (n == "="); r.kind = r.two ? 6'd22 : 6'd21; end
            "|": begin r.two = (n == "|"); r.hit = r.two; r.kind = 6'd23; end
            "-":
            begin
                r.two  = (n == ">") || (n == "=");
                r.kind = (n == ">") ? 6'd25 : (n == "=") ? 6'd26 : 6'd24;
            end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // keyword lookup on the first bytes of a word, little-endian packed
    function automatic kw_t kw_match(input logic [55:0] p, input logic [15:0] len);
        kw_t r;
        r.hit  = 1'b1;
        r.kind = K_FN;
        if (len == 16'd2 && p == 56'(16'h6E66))
            r.kind = K_FN;
        else if (len == 16'd3 && p == 56'(24'h676572))
            r.kind = 6'd28;
        else if (len == 16'd6 && p == 56'(48'h6E7275746572))
            r.kind = 6'd29;
        else if (len == 16'd4 && p == 56'(32'h64696F76))
            r.kind = 6'd30;
        else if (len == 16'd2 && p == 56'(16'h6669))
            r.kind = 6'd31;
        else if (len == 16'd4 && p == 56'(32'h65736C65))
            r.kind = 6'd32;
        else if (len == 16'd5 && p == 56'(40'h656C696877))
            r.kind = 6'd33;
        else if (len == 16'd3 && p == 56'(24'h726F66))
            r.kind = 6'd34;
        else if (len == 16'd2 && p == 56'(16'h3875))
            r.kind = 6'd35;
        else if (len == 16'd2 && p == 56'(16'h3869))
            r.kind = 6'd36;
        else if (len == 16'd3 && p == 56'(24'h363175))
            r.kind = 6'd37;
        else if (len == 16'd3 && p == 56'(24'h363169))
            r.kind = 6'd38;
        else if (len == 16'd4 && p == 56'(32'h6C6C756E))
            r.kind = K_NUMBER;
        else
            r.hit = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/slx_front.sv =====
// ----------------------------------------------------------------------------
// slx_front
// Lexer core: takes one byte per transfer, classifies it against the held
// character and writes up to two result records into the queue.
// ----------------------------------------------------------------------------
module slx_front #(
    parameter int LINE_WIDTH   = slx_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = slx_pkg::COLUMN_WIDTH_DEF,
    parameter int OFFSET_WIDTH = slx_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [7:0]                          byte_in,
    input  logic                                is_end,
    input  logic [slx_pkg::TOKEN_LIMIT_W-1:0]   token_limit,
    output slx_pkg::push_t                      push,
    output slx_pkg::rec_t                       rec0,
    output slx_pkg::rec_t                       rec1
);

    slx_pkg::mode_t            mode_reg, mode_next;
    logic [7:0]                pend_reg, pend_next;
    logic                      pend_v_reg, pend_v_next;
    logic [LINE_WIDTH-1:0]     line_reg, line_next;
    logic [COLUMN_WIDTH-1:0]   col_reg, col_next;
    logic [OFFSET_WIDTH-1:0]   off_reg, off_next;
    logic [LINE_WIDTH-1:0]     tline_reg, tline_next;
    logic [COLUMN_WIDTH-1:0]   tcol_reg, tcol_next;
    logic [OFFSET_WIDTH-1:0]   toff_reg, toff_next;
    logic [55:0]               wpre_reg, wpre_next;
    logic [15:0]               wlen_reg, wlen_next;
    slx_pkg::value_t           acc_reg, acc_next;
    slx_pkg::cnt_t             cnt_reg, cnt_next;
    slx_pkg::status_t          err_reg, err_next;

    always_comb
    begin
        logic [7:0]       c;
        logic [7:0]       n;
        logic             is_eof;
        logic             adv;
        logic             adv_nl;
        logic             dispatch;
        logic             fail_v;
        slx_pkg::status_t fail_code;
        logic             tok_v;
        slx_pkg::kind_t   tok_kind;
        logic             tok_text;
        slx_pkg::value_t  tok_val;
        logic             finish;
        slx_pkg::sym_t    sym;
        slx_pkg::kw_t     kw;
        slx_pkg::rec_t    tok_rec;
        slx_pkg::rec_t    eof_rec;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        off_next    = off_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        toff_next   = toff_reg;
        wpre_next   = wpre_reg;
        wlen_next   = wlen_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;

        c         = pend_reg;
        is_eof    = is_end || (byte_in == 8'd0);
        n         = is_eof ? 8'd0 : byte_in;
        adv       = 1'b0;
        adv_nl    = 1'b0;
        dispatch  = 1'b0;
        fail_v    = 1'b0;
        fail_code = slx_pkg::ST_OK;
        tok_v     = 1'b0;
        tok_kind  = slx_pkg::K_NUMBER;
        tok_text  = 1'b0;
        tok_val   = '0;
        finish    = 1'b0;
        sym       = slx_pkg::symbol_kind(c, n);
        kw        = '0;
        tok_rec   = '0;
        eof_rec   = '0;
        push      = '0;
        rec0      = '0;
        rec1      = '0;

        if (fire)
        begin
            // limit check at the start of every transfer
            if (err_next == slx_pkg::ST_OK && cnt_reg >= slx_pkg::cnt_t'(token_limit))
            begin
                err_next  = slx_pkg::ST_LIMIT;
                mode_next = slx_pkg::M_HALT;
            end

            if (pend_v_reg)
            begin
                case (mode_next)
                    slx_pkg::M_HALT: ;
                    slx_pkg::M_SKIP:
                    begin
                        adv = 1'b1;
                        mode_next = slx_pkg::M_IDLE;
                    end
                    slx_pkg::M_SKIP_LINE:
                    begin
                        adv = 1'b1;
                        mode_next = slx_pkg::M_LINE;
                    end
                    slx_pkg::M_SKIP_BLOCK:
                    begin
                        adv = 1'b1;
                        mode_next = slx_pkg::M_BLOCK;
                    end
                    slx_pkg::M_LINE:
                    begin
                        if (c != "\n")
                            adv = 1'b1;
                        else
                            dispatch = 1'b1;
                    end
                    slx_pkg::M_BLOCK:
                    begin
                        adv = 1'b1;
                        if (c == "*" && n == "/")
                            mode_next = slx_pkg::M_SKIP;
                        else
                            adv_nl = 1'b1;
                    end
                    slx_pkg::M_SKIP_HEX, slx_pkg::M_SKIP_BIN:
                    begin
                        adv = 1'b1;
                        if (slx_pkg::in_base(mode_next, n))
                            mode_next = (mode_next == slx_pkg::M_SKIP_HEX) ?
                                        slx_pkg::M_HEX : slx_pkg::M_BIN;
                        else
                        begin
                            fail_v    = 1'b1;
                            fail_code = slx_pkg::ST_BAD_NUMBER;
                        end
                    end
                    slx_pkg::M_IDENT:
                    begin
                        if (wlen_next < 16'd7)
                            wpre_next = wpre_next | (56'(c) << {wlen_next[2:0], 3'b000});
                        if (wlen_next != 16'hFFFF)
                            wlen_next = wlen_next + 16'd1;
                        adv = 1'b1;
                        if (!slx_pkg::is_ident(n))
                        begin
                            mode_next = slx_pkg::M_IDLE;
                            finish    = 1'b1;
                        end
                    end
                    slx_pkg::M_STR:
                    begin
                        if (c == "\"")
                        begin
                            adv       = 1'b1;
                            mode_next = slx_pkg::M_IDLE;
                            tok_v     = 1'b1;
                            tok_kind  = slx_pkg::K_STRING;
                            tok_text  = 1'b1;
                        end
                        else if (c == "\n")
                        begin
                            fail_v    = 1'b1;
                            fail_code = slx_pkg::ST_UNTERM_STR;
                        end
                        else
                        begin
                            adv = 1'b1;
                            if (wlen_next != 16'hFFFF)
                                wlen_next = wlen_next + 16'd1;
                            if (c == "\\")
                                mode_next = slx_pkg::M_STR_ESC;
                        end
                    end
                    slx_pkg::M_STR_ESC:
                    begin
                        adv = 1'b1;
                        if (wlen_next != 16'hFFFF)
                            wlen_next = wlen_next + 16'd1;
                        mode_next = slx_pkg::M_STR;
                    end
                    slx_pkg::M_DEC, slx_pkg::M_HEX, slx_pkg::M_BIN:
                    begin
                        acc_next = slx_pkg::acc_step(acc_reg, mode_next,
                                                     slx_pkg::digit_value(c));
                        adv = 1'b1;
                        if (!slx_pkg::in_base(mode_next, n))
                        begin
                            mode_next = slx_pkg::M_IDLE;
                            tok_v     = 1'b1;
                            tok_kind  = slx_pkg::K_NUMBER;
                            tok_val   = acc_next;
                        end
                    end
                    default: dispatch = 1'b1;
                endcase

                if (dispatch)
                begin
                    mode_next = slx_pkg::M_IDLE;
                    if (slx_pkg::is_space(c))
                    begin
                        adv    = 1'b1;
                        adv_nl = 1'b1;
                    end
                    else if (c == "/" && n == "/")
                    begin
                        adv       = 1'b1;
                        mode_next = slx_pkg::M_SKIP_LINE;
                    end
                    else if (c == "/" && n == "*")
                    begin
                        adv       = 1'b1;
                        mode_next = slx_pkg::M_SKIP_BLOCK;
                    end
                    else
                    begin
                        tline_next = line_reg;
                        tcol_next  = col_reg;
                        toff_next  = off_reg;
                        if (sym.hit)
                        begin
                            adv       = 1'b1;
                            mode_next = sym.two ? slx_pkg::M_SKIP : slx_pkg::M_IDLE;
                            tok_v     = 1'b1;
                            tok_kind  = sym.kind;
                        end
                        else if (c == "\"")
                        begin
                            toff_next = off_reg + 1'b1;
                            wlen_next = '0;
                            adv       = 1'b1;
                            mode_next = slx_pkg::M_STR;
                        end
                        else if (slx_pkg::is_digit(c))
                        begin
                            acc_next = '0;
                            adv      = 1'b1;
                            if (c == "0" && (n == "x" || n == "X"))
                                mode_next = slx_pkg::M_SKIP_HEX;
                            else if (c == "0" && (n == "b" || n == "B"))
                                mode_next = slx_pkg::M_SKIP_BIN;
                            else
                            begin
                                acc_next = slx_pkg::value_t'(slx_pkg::digit_value(c));
                                if (slx_pkg::is_digit(n))
                                    mode_next = slx_pkg::M_DEC;
                                else
                                begin
                                    tok_v    = 1'b1;
                                    tok_kind = slx_pkg::K_NUMBER;
                                    tok_val  = acc_next;
                                end
                            end
                        end
                        else if (slx_pkg::is_alpha(c) || c == "_")
                        begin
                            wpre_next = 56'(c);
                            wlen_next = 16'd1;
                            adv       = 1'b1;
                            if (slx_pkg::is_ident(n))
                                mode_next = slx_pkg::M_IDENT;
                            else
                                finish = 1'b1;
                        end
                        else
                        begin
                            fail_v    = 1'b1;
                            fail_code = slx_pkg::ST_UNEXPECTED;
                        end
                    end
                end

                if (finish)
                begin
                    kw       = slx_pkg::kw_match(wpre_next, wlen_next);
                    tok_v    = 1'b1;
                    tok_kind = kw.hit ? kw.kind : slx_pkg::K_IDENT;
                    tok_text = !kw.hit;
                end

                if (fail_v)
                begin
                    if (err_next == slx_pkg::ST_OK)
                        err_next = fail_code;
                    mode_next = slx_pkg::M_HALT;
                end

                if (adv)
                begin
                    if (adv_nl && c == "\n")
                    begin
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                        col_next = COLUMN_WIDTH'(1);
                    end
                    else if (col_reg != '1)
                        col_next = col_reg + 1'b1;
                    off_next = off_reg + 1'b1;
                end

                if (tok_v)
                begin
                    if (cnt_next != slx_pkg::CNT_SAT)
                        cnt_next = cnt_next + 1'b1;
                    tok_rec.kind         = tok_kind;
                    tok_rec.line         = slx_pkg::line_t'(tline_next);
                    tok_rec.column       = slx_pkg::col_t'(tcol_next);
                    tok_rec.start_offset = tok_text ? slx_pkg::off_t'(toff_next) : '0;
                    tok_rec.text_length  = tok_text ? wlen_next : '0;
                    tok_rec.number_value = tok_val;
                    tok_rec.status       = slx_pkg::ST_OK;
                    tok_rec.token_count  = cnt_next;
                    tok_rec.last         = 1'b0;
                    if (err_next == slx_pkg::ST_OK &&
                        cnt_next >= slx_pkg::cnt_t'(token_limit))
                    begin
                        err_next  = slx_pkg::ST_LIMIT;
                        mode_next = slx_pkg::M_HALT;
                    end
                end
            end

            if (!is_eof)
            begin
                pend_next   = byte_in;
                pend_v_next = 1'b1;
            end
            else
            begin
                if (mode_next == slx_pkg::M_STR || mode_next == slx_pkg::M_STR_ESC)
                begin
                    if (err_next == slx_pkg::ST_OK)
                        err_next = slx_pkg::ST_UNTERM_STR;
                end
                if (err_next == slx_pkg::ST_OK && cnt_next >= slx_pkg::cnt_t'(token_limit))
                    err_next = slx_pkg::ST_LIMIT;
                eof_rec.kind         = slx_pkg::K_EOF;
                eof_rec.line         = slx_pkg::line_t'(line_next);
                eof_rec.column       = slx_pkg::col_t'(col_next);
                eof_rec.status       = err_next;
                eof_rec.token_count  = (err_next == slx_pkg::ST_OK) ? cnt_next + 1'b1 : cnt_next;
                eof_rec.last         = 1'b1;

                // a new source begins after eof
                mode_next   = slx_pkg::M_IDLE;
                pend_next   = '0;
                pend_v_next = 1'b0;
                line_next   = LINE_WIDTH'(1);
                col_next    = COLUMN_WIDTH'(1);
                off_next    = '0;
                tline_next  = '0;
                tcol_next   = '0;
                toff_next   = '0;
                wpre_next   = '0;
                wlen_next   = '0;
                acc_next    = '0;
                cnt_next    = '0;
                err_next    = slx_pkg::ST_OK;
            end

            if (tok_v)
            begin
                push.v0 = 1'b1;
                push.v1 = is_eof;
                rec0    = tok_rec;
                rec1    = eof_rec;
            end
            else
            begin
                push.v0 = is_eof;
                rec0    = eof_rec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= slx_pkg::M_IDLE;
            pend_reg   <= '0;
            pend_v_reg <= 1'b0;
            line_reg   <= LINE_WIDTH'(1);
            col_reg    <= COLUMN_WIDTH'(1);
            off_reg    <= '0;
            tline_reg  <= '0;
            tcol_reg   <= '0;
            toff_reg   <= '0;
            wpre_reg   <= '0;
            wlen_reg   <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            err_reg    <= slx_pkg::ST_OK;
        end
        else
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pend_v_reg <= pend_v_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            off_reg    <= off_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            toff_reg   <= toff_next;
            wpre_reg   <= wpre_next;
            wlen_reg   <= wlen_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== rtl/slx_queue.sv =====
// ----------------------------------------------------------------------------
// slx_queue
// Short result queue between lexer core and output stage; up to two writes and
// one read per cycle.
// ----------------------------------------------------------------------------
module slx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  slx_pkg::push_t push,
    input  slx_pkg::rec_t  rec0,
    input  slx_pkg::rec_t  rec1,
    output logic           room,
    input  logic           pop,
    output logic           head_valid,
    output slx_pkg::rec_t  head
);

    slx_pkg::rec_t              slot_reg [slx_pkg::QDEPTH];
    logic [slx_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [slx_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [slx_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic [slx_pkg::QPTR_W-1:0] wr_plus1;
    logic [slx_pkg::QCNT_W-1:0] n_push;

    assign wr_plus1   = wr_reg + 1'b1;
    assign n_push     = slx_pkg::QCNT_W'(push.v0) + slx_pkg::QCNT_W'(push.v1);
    // room for a whole transfer's worth of results
    assign room       = cnt_reg <= slx_pkg::QCNT_W'(slx_pkg::QDEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + slx_pkg::QPTR_W'(n_push);
        rd_next  = rd_reg + slx_pkg::QPTR_W'(pop);
        cnt_next = cnt_reg + n_push - slx_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            slot_reg[wr_reg] <= rec0;
        if (push.v1)
            slot_reg[wr_plus1] <= rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= slx_pkg::QCNT_W'(slx_pkg::QDEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty result queue");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result written without first");

    a_fill_level: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ((wr_reg - rd_reg) == slx_pkg::QPTR_W'(cnt_reg)))
        else $error("queue pointers and fill level disagree");

endmodule

// ===== rtl/slx_back.sv =====
// ----------------------------------------------------------------------------
// slx_back
// Output stage: takes records from the queue into a register and packs them
// onto the master stream.
// ----------------------------------------------------------------------------
module slx_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  slx_pkg::rec_t                 head,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [slx_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [5:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    slx_pkg::rec_t rec_reg;
    logic          valid_reg, valid_next;

    assign pop        = head_valid && (!valid_reg || m_axis_tready);
    assign valid_next = pop || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = rec_reg.kind;
    assign m_axis_tlast  = rec_reg.last;
    assign m_axis_tdata  = {{slx_pkg::PAD_W{1'b0}}, rec_reg.token_count, rec_reg.status,
                            rec_reg.number_value, rec_reg.text_length, rec_reg.start_offset,
                            rec_reg.column, rec_reg.line};

endmodule

// ===== rtl/source_lexer.sv =====
// ----------------------------------------------------------------------------
// source_lexer
// Streaming tokenizer: one source byte per transfer in, tokens and a final
// eof status record out.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis_*     in   tdata[7:0] byte_in, tlast is_end
//  m_axis_*     out  tdata line/column/offset/length/value/status/count,
//                    tuser kind, tlast last
//  apb          in   token_limit at byte address 0
//
//  one byte per cycle while the queue has room; the lexer core decides a held
//  byte at the next transfer; results pass the queue, then the output register
//  a byte is taken while the four-entry result queue has two free entries,
//  so a stalled output stops input before the queue overflows
//  reset clears all lexing state; token_limit returns to 65535
// ----------------------------------------------------------------------------
module source_lexer #(
    parameter int LINE_WIDTH   = slx_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = slx_pkg::COLUMN_WIDTH_DEF,
    parameter int OFFSET_WIDTH = slx_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // byte_in
    input  logic                          s_axis_tlast,   // is_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // line, column, start_offset, text_length, number_value, status, token_count
    output logic [slx_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [5:0]                    m_axis_tuser,   // kind
    output logic                          m_axis_tlast,   // last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [slx_pkg::TOKEN_LIMIT_W-1:0] limit_reg;
    logic                              fire;
    logic                              room;
    logic                              pop;
    logic                              head_valid;
    slx_pkg::push_t                    push;
    slx_pkg::rec_t                     rec0;
    slx_pkg::rec_t                     rec1;
    slx_pkg::rec_t                     head;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : 32'(limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= slx_pkg::TOKEN_LIMIT_RST;
        else if (psel && penable && pwrite && pready && !paddr[2])
            limit_reg <= pwdata[slx_pkg::TOKEN_LIMIT_W-1:0];
    end

    assign s_axis_tready = room;
    assign fire          = s_axis_tvalid && room;

    slx_front #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .byte_in     (s_axis_tdata),
        .is_end      (s_axis_tlast),
        .token_limit (limit_reg),
        .push        (push),
        .rec0        (rec0),
        .rec1        (rec1)
    );

    slx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rec0       (rec0),
        .rec1       (rec1),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    slx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
